FILE: hw/rtl/fan_tacho_debounce_average_macros.svh
// Assertion shorthands for the tachometer checker.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef FAN_TACHO_DEBOUNCE_AVERAGE_MACROS_SVH
`define FAN_TACHO_DEBOUNCE_AVERAGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FTDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ftda_pkg.sv
package ftda_pkg;

	// Input command codes.
	localparam logic CMD_PULSE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_PPR     = 2'd0;
	localparam logic [1:0] REG_RPM_MAX = 2'd1;
	localparam logic [1:0] REG_RPM_MIN = 2'd2;
	localparam logic [1:0] REG_MIN_GAP = 2'd3;

	// Configuration reset values.
	localparam logic [3:0]  PPR_RESET     = 4'd3;
	localparam logic [15:0] RPM_MAX_RESET = 16'd6000;
	localparam logic [15:0] RPM_MIN_RESET = 16'd100;
	localparam logic [7:0]  MIN_GAP_RESET = 8'd2;

	// Pulses per revolution fallback for out-of-range settings.
	localparam logic [3:0] PPR_DEFAULT = 4'd3;

	// Field widths.
	localparam int RPM_W   = 16;
	localparam int STAMP_W = 8;
	localparam int CFG_W   = 16;
	// Tally times sixty fits in this many bits.
	localparam int PROD_W  = RPM_W + 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;      // capture the accepted input transaction
		logic pulse;      // debounce check and tally update
		logic tick_load;  // start the rpm divide, clear tally, read oldest sample
		logic raw_take;   // store the rpm quotient
		logic offer;      // outlier check and ring update
		logic mean_load;  // start the mean divide
		logic mean_take;  // store the mean quotient
		logic out_load;   // load the result register
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic div_done;
		logic keep;
	} sts_t;

endpackage

FILE: hw/rtl/ftda_in_if.sv
interface ftda_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] ms_stamp;

	modport source (output valid, output cmd, output ms_stamp, input ready);
	modport sink (input valid, input cmd, input ms_stamp, output ready);
endinterface

FILE: hw/rtl/ftda_out_if.sv
interface ftda_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] filtered_rpm;
	logic [15:0] raw_rpm;
	logic        pulse_accepted;
	logic        sample_kept;

	modport source (output valid, output filtered_rpm, output raw_rpm,
		output pulse_accepted, output sample_kept, input ready);
	modport sink (input valid, input filtered_rpm, input raw_rpm,
		input pulse_accepted, input sample_kept, output ready);
endinterface

FILE: hw/rtl/ftda_div.sv
// Restoring divider, one quotient bit per cycle.
module ftda_div #(
	parameter int DND_W = 22,
	parameter int DVS_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DND_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DND_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DND_W + 1);

	logic [DND_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W:0]   diff;

	// Shift in the next dividend bit and test the subtraction.
	always_comb begin
		trial = {rem_q, quo_q[DND_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DND_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: hw/rtl/ftda_datapath.sv
// Configuration, pulse tally, sample ring, running sum and result register.
module ftda_datapath #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_cmd,
	input  logic [7:0]               in_stamp,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_wdata,
	input  ftda_pkg::ctl_t           ctl,
	output ftda_pkg::sts_t           sts,
	output logic [15:0]              filtered_rpm,
	output logic [15:0]              raw_rpm,
	output logic                     pulse_accepted,
	output logic                     sample_kept
);
	localparam int RPM_W  = ftda_pkg::RPM_W;
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W  = RPM_W + CNT_W;
	localparam int DND_W  = (SUM_W > ftda_pkg::PROD_W) ? SUM_W : ftda_pkg::PROD_W;
	localparam int DVS_W  = (CNT_W > 4) ? CNT_W : 4;

	// Configuration registers.
	logic [3:0]       ppr_q;
	logic [RPM_W-1:0] rpm_max_q;
	logic [RPM_W-1:0] rpm_min_q;
	logic [7:0]       min_gap_q;

	// Persistent state.
	logic [RPM_W-1:0]   tally_q;
	logic [7:0]         last_stamp_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   filled_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RPM_W-1:0]   mean_q;
	logic [RPM_W-1:0]   ring [WINDOW_DEPTH];

	// Per-transaction registers.
	logic               tick_q;
	logic [7:0]         stamp_q;
	logic [RPM_W-1:0]   raw_q;
	logic               acc_q;
	logic               kept_q;
	logic [RPM_W-1:0]   old_q;

	// Result register.
	logic [RPM_W-1:0]   res_filtered_q;
	logic [RPM_W-1:0]   res_raw_q;
	logic               res_acc_q;
	logic               res_kept_q;

	logic [7:0]                  gap;
	logic [3:0]                  ppr_eff;
	logic [ftda_pkg::PROD_W-1:0] prod;
	logic                        keep;
	logic                        full;
	logic                        div_start;
	logic [DND_W-1:0]            div_dnd;
	logic [DVS_W-1:0]            div_dvs;
	logic                        div_done;
	logic [DND_W-1:0]            div_quo;

	// Debounce gap, effective pulses per revolution and the tally scaled by 60.
	always_comb begin
		gap = stamp_q - last_stamp_q;
		if (ppr_q inside {4'd0, [4'd10:4'd15]}) begin
			ppr_eff = ftda_pkg::PPR_DEFAULT;
		end else begin
			ppr_eff = ppr_q;
		end
		prod = {tally_q, 6'b0} - {4'b0, tally_q, 2'b0};
	end

	// Outlier window and ring fill state.
	always_comb begin
		keep = !((raw_q > rpm_max_q) || ((raw_q != '0) && (raw_q < rpm_min_q)));
		full = filled_q == CNT_W'(WINDOW_DEPTH);
	end

	// The divider is shared by the rpm and the mean computations.
	always_comb begin
		div_start = ctl.tick_load || ctl.mean_load;
		if (ctl.tick_load) begin
			div_dnd = DND_W'(prod);
			div_dvs = DVS_W'(ppr_eff);
		end else begin
			div_dnd = DND_W'(sum_q);
			div_dvs = DVS_W'(filled_q);
		end
	end

	ftda_div #(
		.DND_W (DND_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dnd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q     <= ftda_pkg::PPR_RESET;
			rpm_max_q <= ftda_pkg::RPM_MAX_RESET;
			rpm_min_q <= ftda_pkg::RPM_MIN_RESET;
			min_gap_q <= ftda_pkg::MIN_GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ftda_pkg::REG_PPR:     ppr_q     <= cfg_wdata[3:0];
				ftda_pkg::REG_RPM_MAX: rpm_max_q <= cfg_wdata;
				ftda_pkg::REG_RPM_MIN: rpm_min_q <= cfg_wdata;
				ftda_pkg::REG_MIN_GAP: min_gap_q <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Tally, ring bookkeeping, running sum and mean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q      <= '0;
			last_stamp_q <= '0;
			slot_q       <= '0;
			filled_q     <= '0;
			sum_q        <= '0;
			mean_q       <= '0;
		end else begin
			if (ctl.pulse && (gap >= min_gap_q)) begin
				tally_q      <= tally_q + 1'b1;
				last_stamp_q <= stamp_q;
			end
			if (ctl.tick_load) begin
				tally_q <= '0;
			end
			if (ctl.offer && keep) begin
				sum_q <= sum_q + SUM_W'(raw_q) - (full ? SUM_W'(old_q) : '0);
				if (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
				if (!full) begin
					filled_q <= filled_q + 1'b1;
				end
			end
			if (ctl.mean_take) begin
				mean_q <= div_quo[RPM_W-1:0];
			end
		end
	end

	// Sample ring: the oldest entry is read ahead of the write that replaces it.
	always_ff @(posedge clk) begin
		if (ctl.tick_load) begin
			old_q <= ring[slot_q];
		end
		if (ctl.offer && keep) begin
			ring[slot_q] <= raw_q;
		end
	end

	// Per-transaction capture and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 1'b0;
			acc_q  <= 1'b0;
			kept_q <= 1'b0;
			raw_q  <= '0;
		end else begin
			if (ctl.latch) begin
				tick_q <= in_cmd == ftda_pkg::CMD_TICK;
				acc_q  <= 1'b0;
				kept_q <= 1'b0;
				raw_q  <= '0;
			end
			if (ctl.pulse) begin
				acc_q <= gap >= min_gap_q;
			end
			if (ctl.raw_take) begin
				raw_q <= div_quo[RPM_W-1:0];
			end
			if (ctl.offer) begin
				kept_q <= keep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			stamp_q <= in_stamp;
		end
		if (ctl.out_load) begin
			res_filtered_q <= mean_q;
			res_raw_q      <= raw_q;
			res_acc_q      <= acc_q;
			res_kept_q     <= kept_q;
		end
	end

	assign sts.is_tick  = tick_q;
	assign sts.div_done = div_done;
	assign sts.keep     = keep;

	assign filtered_rpm   = res_filtered_q;
	assign raw_rpm        = res_raw_q;
	assign pulse_accepted = res_acc_q;
	assign sample_kept    = res_kept_q;
endmodule

FILE: hw/rtl/ftda_ctrl.sv
// Sequencer: one transaction at a time, result handed to the output register.
module ftda_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	output ftda_pkg::ctl_t ctl,
	input  ftda_pkg::sts_t sts
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_PULSE,
		S_TICK,
		S_DIV_RAW,
		S_OFFER,
		S_MEAN,
		S_DIV_MEAN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;

	assign can_load = !out_valid_q || out_ready;

	// Commands decoded from the current state.
	always_comb begin
		ctl           = '0;
		ctl.latch     = (state_q == S_IDLE) && in_valid;
		ctl.pulse     = (state_q == S_PULSE) && !sts.is_tick;
		ctl.tick_load = state_q == S_TICK;
		ctl.raw_take  = (state_q == S_DIV_RAW) && sts.div_done;
		ctl.offer     = state_q == S_OFFER;
		ctl.mean_load = state_q == S_MEAN;
		ctl.mean_take = (state_q == S_DIV_MEAN) && sts.div_done;
		ctl.out_load  = (state_q == S_FINISH) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// The result flag rises on a load and falls once the result is taken.
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PULSE;
					end
				end
				S_PULSE: begin
					// A tick skips the debounce step.
					state_q <= sts.is_tick ? S_TICK : S_FINISH;
				end
				S_TICK: state_q <= S_DIV_RAW;
				S_DIV_RAW: begin
					if (sts.div_done) begin
						state_q <= S_OFFER;
					end
				end
				S_OFFER: begin
					// The mean only moves when a sample enters the ring.
					state_q <= sts.keep ? S_MEAN : S_FINISH;
				end
				S_MEAN: state_q <= S_DIV_MEAN;
				S_DIV_MEAN: begin
					if (sts.div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
endmodule

FILE: hw/rtl/fan_tacho_debounce_average.sv
// Fan tachometer with pulse debounce and moving-average rpm filter.
// Input channel in_ch carries transactions with cmd and ms_stamp: cmd 0 is a
// tach edge stamped with an 8-bit millisecond count, cmd 1 a one-second tick.
// Every input transaction yields exactly one transaction on out_ch with the
// ring mean, this tick's rpm and the pulse and sample flags.
// Configuration: write cfg_we with cfg_index 0..3 (pulses per revolution,
// rpm maximum, rpm minimum, debounce gap) and cfg_wdata, only while idle.
// A pulse runs through the debounce step and is then loaded into the output
// register from the finish state. A tick runs the rpm divide and, when the
// sample is kept, the mean divide, serially on one shared restoring divider,
// one bit a cycle over max(22, 16 + clog2(WINDOW_DEPTH + 1)) bits; a dropped
// sample leaves the mean as is. One transaction is in flight at a time, and
// the next is taken the cycle after a result is loaded.
// Reset clears the tally, the last stamp, the ring fill count and the mean,
// and loads the register defaults; ring entries are only used once written.
// If the receiver stalls, the result waits in the output register; the next
// transaction is still accepted and runs until its own result is ready.
module fan_tacho_debounce_average #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ftda_in_if.sink     in_ch,
	ftda_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	ftda_pkg::ctl_t ctl;
	ftda_pkg::sts_t sts;

	// Sequencer.
	ftda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Datapath with configuration, ring and shared divider.
	ftda_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_cmd         (in_ch.cmd),
		.in_stamp       (in_ch.ms_stamp),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.ctl            (ctl),
		.sts            (sts),
		.filtered_rpm   (out_ch.filtered_rpm),
		.raw_rpm        (out_ch.raw_rpm),
		.pulse_accepted (out_ch.pulse_accepted),
		.sample_kept    (out_ch.sample_kept)
	);
endmodule

FILE: hw/rtl/ftda_checker.sv
`include "fan_tacho_debounce_average_macros.svh"

// Port-level checks for the tachometer.
module ftda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] filtered_rpm,
	input logic [15:0] raw_rpm,
	input logic        pulse_accepted,
	input logic        sample_kept
);
	// A stalled result stays offered.
	`FTDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A stalled result keeps its payload.
	`FTDA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(filtered_rpm) && $stable(raw_rpm) && $stable(pulse_accepted) && $stable(sample_kept), "result changed while stalled")

	// An accepted pulse carries no rpm and no sample.
	`FTDA_ASSERT_NOW(a_pulse_clean, out_valid && pulse_accepted, raw_rpm == 16'd0 && !sample_kept, "pulse result carries tick fields")

	// Only one transaction is in work at a time.
	`FTDA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")
endmodule

bind fan_tacho_debounce_average ftda_checker u_ftda_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.filtered_rpm   (out_ch.filtered_rpm),
	.raw_rpm        (out_ch.raw_rpm),
	.pulse_accepted (out_ch.pulse_accepted),
	.sample_kept    (out_ch.sample_kept)
);

FILE: bench/tb.sv
module tb;
	localparam int    RING_DEPTH  = 8;
	localparam int    SETTLE_GAP  = 4;
	localparam int    TAIL_CYCLES = 80;
	localparam longint CYCLE_LIMIT = 1_000_000;

	// One expected reading from the tachometer.
	typedef struct packed {
		logic [15:0] filtered;
		logic [15:0] raw;
		logic        accepted;
		logic        kept;
	} reading_t;

	logic clk;
	logic arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	ftda_in_if  in_ch();
	ftda_out_if out_ch();

	fan_tacho_debounce_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the settings and of the tachometer state.
	logic [3:0]  set_ppr;
	logic [15:0] set_rpm_max;
	logic [15:0] set_rpm_min;
	logic [7:0]  set_min_gap;
	logic [15:0] tally;
	logic [7:0]  last_stamp;
	logic [15:0] rpm_ring [RING_DEPTH];
	int          ring_wr;
	int          ring_fill;

	reading_t pending_readings[$];

	int  mismatches;
	int  readings_seen;
	int  samples_kept;
	int  items_sent;
	int  ticks_sent;
	int  burst_left;
	bit  steady;
	logic [7:0] train_stamp;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Puts the shadow state at its reset values.
	function automatic void tach_reset();
		set_ppr     = ftda_pkg::PPR_RESET;
		set_rpm_max = ftda_pkg::RPM_MAX_RESET;
		set_rpm_min = ftda_pkg::RPM_MIN_RESET;
		set_min_gap = ftda_pkg::MIN_GAP_RESET;
		tally       = '0;
		last_stamp  = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			rpm_ring[i] = '0;
		ring_wr   = 0;
		ring_fill = 0;
	endfunction

	// Advances the shadow state by one transaction and returns its reading.
	function automatic reading_t tach_advance(input logic cmd, input logic [7:0] stamp);
		reading_t    r;
		logic [7:0]  elapsed;
		logic [3:0]  eff_ppr;
		logic [21:0] product;
		logic [21:0] quotient;
		logic [15:0] rpm;
		int unsigned sum;
		r = '0;
		if (cmd == ftda_pkg::CMD_PULSE) begin
			// Debounce: the gap wraps with the millisecond counter.
			elapsed = stamp - last_stamp;
			if (elapsed >= set_min_gap) begin
				tally      = tally + 16'd1;
				last_stamp = stamp;
				r.accepted = 1'b1;
			end
		end else begin
			// Out-of-range pulse counts fall back to the default.
			eff_ppr  = (set_ppr == 4'd0 || set_ppr >= 4'd10) ? ftda_pkg::PPR_DEFAULT
				: set_ppr;
			product  = 22'(tally) * 22'd60;
			quotient = product / 22'(eff_ppr);
			rpm      = quotient[15:0];
			r.raw    = rpm;
			tally    = '0;
			// Outlier filter; a zero rpm only has to respect the maximum.
			if (!(rpm > set_rpm_max || (rpm != 16'd0 && rpm < set_rpm_min))) begin
				rpm_ring[ring_wr] = rpm;
				ring_wr = (ring_wr + 1) % RING_DEPTH;
				if (ring_fill < RING_DEPTH)
					ring_fill++;
				r.kept = 1'b1;
			end
		end
		sum = 0;
		for (int i = 0; i < ring_fill; i++)
			sum += rpm_ring[i];
		r.filtered = (ring_fill == 0) ? 16'd0 : 16'(sum / ring_fill);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 30)
			$display("mismatch on reading %0d: %s", readings_seen, what);
	endtask

	// Sends one transaction, with random gaps between bursts unless steady.
	task automatic send_item(input logic cmd, input logic [7:0] stamp);
		int pause;
		if (!steady) begin
			if (burst_left == 0) begin
				pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				burst_left = $urandom_range(1, 24);
				if (pause > 0) begin
					in_ch.valid <= 1'b0;
					repeat (pause) @(negedge clk);
				end
			end
			burst_left--;
		end
		in_ch.valid    <= 1'b1;
		in_ch.cmd      <= cmd;
		in_ch.ms_stamp <= stamp;
		do @(posedge clk); while (!in_ch.ready);
		pending_readings.push_back(tach_advance(cmd, stamp));
		items_sent++;
		if (cmd == ftda_pkg::CMD_TICK)
			ticks_sent++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every reading has come back.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// Writes all four registers while idle; unused upper bits carry noise.
	task automatic set_config(input logic [3:0] ppr, input logic [15:0] rpm_max,
		input logic [15:0] rpm_min, input logic [7:0] min_gap);
		logic [15:0] word;
		settle();
		word = 16'($urandom);
		word[3:0] = ppr;
		write_reg(ftda_pkg::REG_PPR, word);
		write_reg(ftda_pkg::REG_RPM_MAX, rpm_max);
		write_reg(ftda_pkg::REG_RPM_MIN, rpm_min);
		word = 16'($urandom);
		word[7:0] = min_gap;
		write_reg(ftda_pkg::REG_MIN_GAP, word);
		cfg_we      <= 1'b0;
		set_ppr     = ppr;
		set_rpm_max = rpm_max;
		set_rpm_min = rpm_min;
		set_min_gap = min_gap;
	endtask

	// Debounce at the reset settings: gaps from the reset stamp and across the wrap.
	task automatic test_debounce();
		send_item(ftda_pkg::CMD_TICK, 8'd0);
		send_item(ftda_pkg::CMD_PULSE, 8'd0);
		send_item(ftda_pkg::CMD_PULSE, 8'd1);
		send_item(ftda_pkg::CMD_PULSE, 8'd2);
		send_item(ftda_pkg::CMD_PULSE, 8'd255);
		send_item(ftda_pkg::CMD_PULSE, 8'd0);
		send_item(ftda_pkg::CMD_PULSE, 8'd1);
		send_item(ftda_pkg::CMD_PULSE, 8'd3);
		send_item(ftda_pkg::CMD_TICK, 8'd200);
	endtask

	// Pulse count fallback, rpm limits at their edges and the extreme gaps.
	task automatic test_limits();
		set_config(4'd15, 16'd100, 16'd100, 8'd0);
		repeat (5) send_item(ftda_pkg::CMD_PULSE, 8'd77);
		send_item(ftda_pkg::CMD_TICK, 8'd77);
		set_config(4'd9, 16'hFFFF, 16'd0, 8'd255);
		send_item(ftda_pkg::CMD_PULSE, 8'd255);
		send_item(ftda_pkg::CMD_PULSE, 8'd76);
		send_item(ftda_pkg::CMD_TICK, 8'hFF);
		set_config(4'd10, 16'd0, 16'hFFFF, 8'd8);
		send_item(ftda_pkg::CMD_TICK, 8'd0);
		send_item(ftda_pkg::CMD_PULSE, 8'd84);
		send_item(ftda_pkg::CMD_TICK, 8'd0);
	endtask

	// More kept samples than the ring holds, so the oldest get overwritten.
	task automatic test_ring_wrap();
		set_config(4'd0, 16'hFFFF, 16'd0, 8'd0);
		for (int i = 0; i < RING_DEPTH + 1; i++) begin
			if (i % 2 == 1)
				send_item(ftda_pkg::CMD_PULSE, 8'($urandom));
			send_item(ftda_pkg::CMD_TICK, 8'($urandom));
		end
	endtask

	// Long pulse train whose rpm runs past 16 bits.
	task automatic test_tally_limits();
		steady = 1'b1;
		set_config(4'd1, 16'hFFFF, 16'd0, 8'd0);
		repeat (1093) send_item(ftda_pkg::CMD_PULSE, 8'($urandom));
		send_item(ftda_pkg::CMD_TICK, 8'd0);
		settle();
		steady = 1'b0;
	endtask

	// Mostly plausible pulse trains with ticks, plus bounces and stray items.
	task automatic test_random_traffic();
		logic [3:0]  ppr;
		logic [15:0] rpm_max;
		logic [15:0] rpm_min;
		logic [7:0]  min_gap;
		int period;
		int pulses_left;
		int roll;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin
					ppr = 4'd0; rpm_max = 16'd0; rpm_min = 16'd0; min_gap = 8'd0;
				end
				1: begin
					ppr = 4'd15; rpm_max = 16'hFFFF; rpm_min = 16'hFFFF; min_gap = 8'd255;
				end
				2: begin
					ppr = 4'd9; rpm_max = 16'hFFFF; rpm_min = 16'd0; min_gap = 8'd1;
				end
				default: begin
					ppr = 4'($urandom_range(0, 15));
					rpm_min = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 1500));
					roll = $urandom_range(0, 3);
					if (roll == 0)
						rpm_max = 16'hFFFF;
					else if (roll == 1)
						rpm_max = 16'($urandom);
					else
						rpm_max = 16'($urandom_range(rpm_min, 4000));
					min_gap = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
				end
			endcase
			set_config(ppr, rpm_max, rpm_min, min_gap);
			period = min_gap + $urandom_range(0, 30);
			if (period > 255)
				period = 255;
			pulses_left = $urandom_range(0, 48);
			for (int k = 0; k < 48; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 12) begin
					send_item($urandom_range(0, 1) ? ftda_pkg::CMD_TICK : ftda_pkg::CMD_PULSE,
						8'($urandom));
				end else if (pulses_left == 0) begin
					send_item(ftda_pkg::CMD_TICK, 8'($urandom));
					pulses_left = $urandom_range(0, 48);
				end else begin
					if (roll < 22)
						train_stamp = train_stamp + 8'($urandom_range(0, min_gap));
					else
						train_stamp = train_stamp + 8'(period + $urandom_range(0, 3));
					send_item(ftda_pkg::CMD_PULSE, train_stamp);
					pulses_left--;
				end
			end
		end
	endtask

	// Output side stalls on patterns that change from span to span; steady mode holds ready high.
	initial begin : sink_pacing
		int span;
		int step;
		int mode;
		logic [7:0] mask;
		span = 0;
		step = 0;
		mask = '1;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 40);
				case (mode)
					0: mask = 8'hFF;
					1: mask = 8'($urandom);
					2: mask = 8'b0000_0001;
					default: mask = 8'b0101_0101;
				endcase
			end
			span--;
			out_ch.ready <= steady ? 1'b1 : mask[step % 8];
			step++;
		end
	end

	// Each reading that leaves the block is compared with the oldest expectation.
	always @(posedge clk) begin : reading_check
		reading_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("reading arrived with no transaction outstanding");
			end else begin
				want = pending_readings.pop_front();
				if (out_ch.filtered_rpm !== want.filtered)
					report_mismatch($sformatf("filtered_rpm got %0d want %0d",
						out_ch.filtered_rpm, want.filtered));
				if (out_ch.raw_rpm !== want.raw)
					report_mismatch($sformatf("raw_rpm got %0d want %0d",
						out_ch.raw_rpm, want.raw));
				if (out_ch.pulse_accepted !== want.accepted)
					report_mismatch($sformatf("pulse_accepted got %b want %b",
						out_ch.pulse_accepted, want.accepted));
				if (out_ch.sample_kept !== want.kept)
					report_mismatch($sformatf("sample_kept got %b want %b",
						out_ch.sample_kept, want.kept));
				if (want.kept)
					samples_kept++;
			end
			readings_seen++;
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		longint cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("fan_tacho_debounce_average verification failed");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= ftda_pkg::REG_PPR;
		cfg_wdata      <= '0;
		in_ch.valid    <= 1'b0;
		in_ch.cmd      <= ftda_pkg::CMD_PULSE;
		in_ch.ms_stamp <= '0;
		mismatches     = 0;
		readings_seen  = 0;
		samples_kept   = 0;
		items_sent     = 0;
		ticks_sent     = 0;
		burst_left     = 0;
		steady         = 1'b0;
		train_stamp    = '0;
		tach_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_debounce();
		test_limits();
		test_ring_wrap();
		test_random_traffic();
		test_tally_limits();

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d transactions (%0d ticks), %0d readings checked, %0d samples kept",
			items_sent, ticks_sent, readings_seen, samples_kept);
		$display("debounce wrap, rpm limits, ring overwrite and rpm overflow; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("fan_tacho_debounce_average verification clean");
		else
			$display("fan_tacho_debounce_average verification failed");
		$finish;
	end

endmodule
